// ----- src/integer_to_ascii_radix_macros.svh -----
// Assertion macros for the integer_to_ascii_radix checker.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define IAR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define IAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/iar_pkg.sv -----
// Shared types, constants and helpers for the integer_to_ascii_radix block.
`timescale 1ns / 1ps
`default_nettype none

package iar_pkg;

  localparam int VALUE_W     = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int MAX_DIGITS  = 32;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int PTR_W       = $clog2(MAX_DIGITS);
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 8'h61;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               signed_mode;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [RADIX_W-1:0] remainder;
  } div_sts_t;

  typedef struct packed {
    logic               clear;
    logic               push;
    logic               pop;
    logic [RADIX_W-1:0] digit;
  } stk_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [RADIX_W-1:0] top;
  } stk_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d >= DIGIT_TEN) begin
      ch = CHAR_A + {2'b00, d} - {2'b00, DIGIT_TEN};
    end else begin
      ch = CHAR_ZERO + {2'b00, d};
    end
    return ch;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end else begin
      b = r;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- src/iar_divider.sv -----
// Iterative restoring divider: 32-bit dividend by radix, four quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module iar_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [iar_pkg::VALUE_W-1:0] dividend,
  input  wire logic [iar_pkg::RADIX_W-1:0] divisor,
  output iar_pkg::div_sts_t                sts
);

  logic                          run_r;
  logic                          done_r;
  logic [iar_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [iar_pkg::VALUE_W-1:0]   quo_r, quo_nxt;
  logic [iar_pkg::RADIX_W-1:0]   rem_r, rem_nxt;
  logic [iar_pkg::RADIX_W-1:0]   div_r;

  // DIV_BITS restoring steps; remainder stays below divisor (<= 36)
  always_comb begin
    logic [iar_pkg::RADIX_W:0] t;
    logic                      ge;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int i = 0; i < iar_pkg::DIV_BITS; i++) begin
      t  = {rem_nxt, quo_nxt[iar_pkg::VALUE_W-1]};
      ge = (t >= {1'b0, div_r});
      rem_nxt = ge ? iar_pkg::RADIX_W'(t - {1'b0, div_r}) : t[iar_pkg::RADIX_W-1:0];
      quo_nxt = {quo_nxt[iar_pkg::VALUE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        quo_r <= dividend;
        rem_r <= '0;
        div_r <= divisor;
      end else if (run_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == iar_pkg::DIV_CNT_W'(iar_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done      = done_r;
  assign sts.quotient  = quo_r;
  assign sts.remainder = rem_r;

endmodule

`default_nettype wire

// ----- src/iar_digit_stack.sv -----
// LIFO of digit values: filled least significant first, drained most significant first.
`timescale 1ns / 1ps
`default_nettype none

module iar_digit_stack (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire iar_pkg::stk_ctl_t ctl,
  output iar_pkg::stk_sts_t      sts
);

  logic [iar_pkg::RADIX_W-1:0] mem_r [iar_pkg::MAX_DIGITS];
  logic [iar_pkg::RADIX_W-1:0] top_r;
  logic [iar_pkg::CNT_W-1:0]   count_r;
  logic [iar_pkg::CNT_W-1:0]   top_idx;
  logic [iar_pkg::CNT_W-1:0]   below_idx;

  assign top_idx   = count_r - iar_pkg::CNT_W'(1);
  assign below_idx = count_r - iar_pkg::CNT_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clear) begin
      count_r <= '0;
    end else if (ctl.push) begin
      count_r <= count_r + iar_pkg::CNT_W'(1);
    end else if (ctl.pop) begin
      count_r <= top_idx;
    end
  end

  // top_r follows the top entry: a push makes the new digit the top,
  // a pop exposes the entry just below.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[count_r[iar_pkg::PTR_W-1:0]] <= ctl.digit;
      top_r <= ctl.digit;
    end else if (ctl.pop) begin
      top_r <= mem_r[below_idx[iar_pkg::PTR_W-1:0]];
    end
  end

  assign sts.count = count_r;
  assign sts.top   = top_r;

endmodule

`default_nettype wire

// ----- src/integer_to_ascii_radix.sv -----
// Top level of the integer to ASCII converter for radix two to thirty-six.
`timescale 1ns / 1ps
`default_nettype none

// Converts a 32-bit value to text in the base held in the radix register
// (written through cfg_we/cfg_wdata, reset 10; 0 and 1 act as 2, 37..63 as
// 36). A request is taken when start is high and busy is low; busy then stays
// high until the final character has been driven. Characters come out most
// significant first, one per out_valid pulse, and the receiver cannot stall
// them: out_valid marks each for exactly one cycle. In signed mode a negative
// value first gives '-' and then the 32-bit negated magnitude, so the most
// negative value prints without wraparound issues as 2147483648. Digits of
// ten and up are 'a'..'z', zero gives "0", and out_req.last marks the final
// character. No terminator is sent.
// One shared divider yields four quotient bits per cycle; each digit takes the
// divide steps, then a step that stores the digit and restarts the divider,
// then every digit is popped at one per cycle. The final character goes out in
// the first idle cycle, where the next request may already be taken. The sign
// adds no time: it goes out while the first digit divides. The radix register
// is to be written only while idle; the user must keep to this, as the block
// itself does not enforce it.
module integer_to_ascii_radix (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire iar_pkg::in_req_t            in_req,
  // character stream
  output logic                             out_valid,
  output iar_pkg::out_req_t                out_req,
  // radix register
  input  wire logic                        cfg_we,
  input  wire logic [iar_pkg::RADIX_W-1:0] cfg_wdata
);

  iar_pkg::state_t             state_r;
  logic [iar_pkg::RADIX_W-1:0] radix_r;
  logic                        out_valid_r;
  iar_pkg::out_req_t           out_req_r;

  logic                        accept;
  logic                        negative;
  logic [iar_pkg::VALUE_W-1:0] magnitude;
  logic                        div_start;
  logic [iar_pkg::VALUE_W-1:0] div_dividend;
  logic                        div_finish;
  logic                        last_pop;
  iar_pkg::div_sts_t           div_sts;
  iar_pkg::stk_ctl_t           stk_ctl;
  iar_pkg::stk_sts_t           stk_sts;

  // Radix register: raw six bits, clamped each time the divider starts a digit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= iar_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  assign busy   = (state_r != iar_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Two's complement negate for negative signed input; 0x80000000 maps to itself.
  assign negative  = in_req.signed_mode && in_req.value[iar_pkg::VALUE_W-1];
  assign magnitude = negative ? (~in_req.value + iar_pkg::VALUE_W'(1)) : in_req.value;

  // Conversion stops once the quotient runs out or the stack is one short of full
  // (the digit being pushed now fills it).
  assign div_finish = (div_sts.quotient == '0) ||
                      (stk_sts.count == iar_pkg::CNT_W'(iar_pkg::MAX_DIGITS - 1));

  // Divider restarts on the fresh magnitude, or on the previous quotient.
  assign div_start    = accept ||
                        ((state_r == iar_pkg::ST_DIV) && div_sts.done && !div_finish);
  assign div_dividend = accept ? magnitude : div_sts.quotient;

  assign last_pop = (stk_sts.count == iar_pkg::CNT_W'(1));

  always_comb begin
    stk_ctl.clear = accept;
    stk_ctl.push  = (state_r == iar_pkg::ST_DIV) && div_sts.done;
    stk_ctl.pop   = (state_r == iar_pkg::ST_EMIT);
    stk_ctl.digit = div_sts.remainder;
  end

  iar_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (iar_pkg::clamp_radix(radix_r)),
    .sts      (div_sts)
  );

  iar_digit_stack u_digit_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .sts   (stk_sts)
  );

  // Sequencer: IDLE -> DIV (one pass per digit) -> EMIT (one pop per cycle).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iar_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        iar_pkg::ST_IDLE: begin
          if (accept) begin
            state_r <= iar_pkg::ST_DIV;
            // sign goes out while the first digit is still dividing
            out_valid_r <= negative;
          end
        end
        iar_pkg::ST_DIV: begin
          if (div_sts.done && div_finish) begin
            state_r <= iar_pkg::ST_EMIT;
          end
        end
        iar_pkg::ST_EMIT: begin
          out_valid_r <= 1'b1;
          if (last_pop) begin
            state_r <= iar_pkg::ST_IDLE;
          end
        end
        default: begin
          state_r <= iar_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Output payload, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_req_r.character <= iar_pkg::CHAR_MINUS;
      out_req_r.last      <= 1'b0;
    end else if (state_r == iar_pkg::ST_EMIT) begin
      out_req_r.character <= iar_pkg::digit_char(stk_sts.top);
      out_req_r.last      <= last_pop;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

`default_nettype wire

// ----- src/iar_checker.sv -----
// Port-level assertion checker for integer_to_ascii_radix, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_radix_macros.svh"

module iar_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire iar_pkg::out_req_t out_req
);

  // a taken request holds the block busy
  `IAR_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy not raised after request")

  // only the final character may appear while idle
  `IAR_ASSERT_SAME(a_idle_only_last, out_valid && !busy, out_req.last, "non-final char while idle")

  // the sign is never the whole number
  `IAR_ASSERT_SAME(a_minus_not_last, out_valid && (out_req.character == iar_pkg::CHAR_MINUS), !out_req.last, "minus sign flagged last")

  // busy drops exactly as the final character shows
  `IAR_ASSERT_SAME(a_done_with_last, $fell(busy), out_valid && out_req.last, "busy fell without final char")

endmodule

bind integer_to_ascii_radix iar_checker u_iar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_req   (out_req)
);

`default_nettype wire
